// ----- rtl/bvx_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte register machine executor.
// Holds opcodes, status codes, controller states and the command and status
// structures shared by the controller and the datapath. Depends on nothing.
package bvx_pkg;

   localparam int DEF_PC_BITS     = 16;
   localparam int DEF_STACK_DEPTH = 32;
   localparam int REG_COUNT       = 16;
   localparam int REG_IDX_BITS    = 4;
   localparam int DIV_STEPS       = 8;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_EXEC  = 1'b1;

   localparam logic [7:0] OP_HALT  = 8'd0;
   localparam logic [7:0] OP_LOAD  = 8'd1;
   localparam logic [7:0] OP_MOV   = 8'd2;
   localparam logic [7:0] OP_PUSH  = 8'd3;
   localparam logic [7:0] OP_POP   = 8'd4;
   localparam logic [7:0] OP_INC   = 8'd5;
   localparam logic [7:0] OP_DEC   = 8'd6;
   localparam logic [7:0] OP_ADD   = 8'd7;
   localparam logic [7:0] OP_SUB   = 8'd8;
   localparam logic [7:0] OP_MUL   = 8'd9;
   localparam logic [7:0] OP_DIV   = 8'd10;
   localparam logic [7:0] OP_CMP   = 8'd11;
   localparam logic [7:0] OP_JMP   = 8'd12;
   localparam logic [7:0] OP_RJMP  = 8'd13;
   localparam logic [7:0] OP_JNZ_F = 8'd14;
   localparam logic [7:0] OP_JNZ_B = 8'd15;
   localparam logic [7:0] OP_JZ_F  = 8'd16;
   localparam logic [7:0] OP_JZ_B  = 8'd17;
   localparam logic [7:0] OP_JLT_F = 8'd18;
   localparam logic [7:0] OP_JLT_B = 8'd19;
   localparam logic [7:0] OP_JLU_F = 8'd20;
   localparam logic [7:0] OP_JLU_B = 8'd21;
   localparam logic [7:0] OP_JGT_F = 8'd22;
   localparam logic [7:0] OP_JGT_B = 8'd23;
   localparam logic [7:0] OP_JLA_F = 8'd24;
   localparam logic [7:0] OP_JLA_B = 8'd25;
   localparam logic [7:0] OP_AND   = 8'd34;
   localparam logic [7:0] OP_OR    = 8'd35;
   localparam logic [7:0] OP_XOR   = 8'd36;
   localparam logic [7:0] OP_NOT   = 8'd37;
   localparam logic [7:0] OP_SHL   = 8'd38;
   localparam logic [7:0] OP_SHR   = 8'd39;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNKNOWN  = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_HALTED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_OPS,
      S_EXECUTE,
      S_DIVIDE,
      S_COMMIT,
      S_CLEAR_SRC
   } state_type;

   typedef struct packed {
      logic load;
      logic cap_ab;
      logic cap_d;
      logic div_start;
      logic commit;
      logic clear_src;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_op;
      logic div_busy;
      logic mov_op;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/bvx_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the executor.
// Sequences operand reads, execution, division, commit and the clearing of a mov source. Uses bvx_pkg.
module bvx_ctrl
   import bvx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ_OPS;
            end
         end
         S_READ_OPS: begin
            cmd.cap_ab = 1'b1;
            state_in   = S_EXECUTE;
         end
         S_EXECUTE: begin
            cmd.cap_d = 1'b1;
            if (st.div_op) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIVIDE: begin
            if (!st.div_busy) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (st.out_free) begin
               cmd.commit = 1'b1;
               state_in   = st.mov_op ? S_CLEAR_SRC : S_IDLE;
            end
         end
         S_CLEAR_SRC: begin
            cmd.clear_src = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bvx_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the executor: register file, stack memory, machine registers,
// bit-serial divider, execute logic and the result register. Uses bvx_pkg.
module bvx_dpath
   import bvx_pkg::*;
#(
   parameter int PC_BITS     = DEF_PC_BITS,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   req_tdata,
   input  logic          req_tuser,
   input  ctrl_cmd_type  cmd,
   output dp_status_type st,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [31:0]   rsp_tdata
);

   localparam int SP_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SP_BITS-1:0] SP_TOP = SP_BITS'(STACK_DEPTH - 1);

   logic                    cmd_ff;
   logic [7:0]              op_ff;
   logic [REG_IDX_BITS-1:0] d_ff;
   logic [REG_IDX_BITS-1:0] s1_ff;
   logic [7:0]              imm_ff;

   logic [7:0]              rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0]    rf_vld_ff;
   logic [REG_IDX_BITS-1:0] rd_addr0;
   logic [REG_IDX_BITS-1:0] rd_addr1;
   logic [7:0]              rd0_ff;
   logic [7:0]              rd1_ff;
   logic                    rd0_vld_ff;
   logic                    rd1_vld_ff;
   logic [7:0]              rd0;
   logic [7:0]              rd1;
   logic                    rf_we;
   logic [REG_IDX_BITS-1:0] rf_waddr;
   logic [7:0]              rf_wdata;

   logic [7:0]              stk_mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0]  stk_vld_ff;
   logic [7:0]              stk_rd_ff;
   logic                    stk_rd_vld_ff;
   logic                    stk_we;
   logic [SP_BITS-1:0]      stk_waddr;
   logic [7:0]              stk_wdata;

   logic [7:0]              a_ff;
   logic [7:0]              b_ff;
   logic [7:0]              off_ff;
   logic [7:0]              pop_ff;

   logic [PC_BITS-1:0]      pc_ff;
   logic [PC_BITS-1:0]      pc_in;
   logic [SP_BITS-1:0]      sp_ff;
   logic [SP_BITS-1:0]      sp_in;
   logic [SP_BITS-1:0]      sp_inc;
   logic [SP_BITS-1:0]      sp_dec;
   logic                    run_ff;
   logic                    run_in;

   logic                    div_busy_ff;
   logic [3:0]              div_cnt_ff;
   logic [7:0]              div_q_ff;
   logic [7:0]              div_r_ff;
   logic [8:0]              div_part;
   logic [8:0]              div_diff;

   logic                    exec_ok;
   logic [PC_BITS-1:0]      pc_step;
   logic [7:0]              res;
   logic [7:0]              rep_val;
   logic                    wrote;
   logic                    jump_take;
   status_type              status;

   logic                    rsp_tvalid_ff;
   logic [31:0]             rsp_tdata_ff;

   assign sp_inc = (sp_ff == SP_TOP) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SP_TOP : sp_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_tuser;
         op_ff  <= req_tdata[31:24];
         d_ff   <= req_tdata[23:20];
         s1_ff  <= req_tdata[19:16];
         imm_ff <= req_tdata[7:0];
      end
      if (cmd.cap_ab) begin
         a_ff <= rd0;
         b_ff <= rd1;
      end
      if (cmd.cap_d) begin
         off_ff <= rd0;
         pop_ff <= stk_rd_vld_ff ? stk_rd_ff : 8'd0;
      end
   end

   assign rd_addr0 = cmd.load ? req_tdata[19:16] : d_ff;
   assign rd_addr1 = req_tdata[15:12];

   always_ff @(posedge clock) begin
      rd0_ff     <= rf_mem[rd_addr0];
      rd1_ff     <= rf_mem[rd_addr1];
      rd0_vld_ff <= rf_vld_ff[rd_addr0];
      rd1_vld_ff <= rf_vld_ff[rd_addr1];
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
   end

   assign rd0 = rd0_vld_ff ? rd0_ff : 8'd0;
   assign rd1 = rd1_vld_ff ? rd1_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      stk_rd_ff     <= stk_mem[sp_inc];
      stk_rd_vld_ff <= stk_vld_ff[sp_inc];
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stk_vld_ff <= '0;
      end else if (stk_we) begin
         stk_vld_ff[stk_waddr] <= 1'b1;
      end
   end

   // Restoring division, one quotient bit per cycle.
   assign div_part = {div_r_ff, div_q_ff[7]};
   assign div_diff = div_part - {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == 4'd1) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff   <= a_ff;
         div_r_ff   <= 8'd0;
         div_cnt_ff <= 4'(DIV_STEPS);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 4'd1;
         if (!div_diff[8]) begin
            div_r_ff <= div_diff[7:0];
            div_q_ff <= {div_q_ff[6:0], 1'b1};
         end else begin
            div_r_ff <= div_part[7:0];
            div_q_ff <= {div_q_ff[6:0], 1'b0};
         end
      end
   end

   assign exec_ok = (cmd_ff == CMD_EXEC) && run_ff;
   assign pc_step = pc_ff + 1'b1;

   always_comb begin
      res       = 8'd0;
      wrote     = 1'b0;
      jump_take = 1'b0;
      status    = ST_OK;
      case (op_ff)
         OP_HALT: begin
            wrote = 1'b0;
         end
         OP_LOAD: begin
            res   = imm_ff;
            wrote = 1'b1;
         end
         OP_MOV: begin
            res   = a_ff;
            wrote = 1'b1;
         end
         OP_PUSH: begin
            wrote = 1'b1;
         end
         OP_POP: begin
            res   = pop_ff;
            wrote = 1'b1;
         end
         OP_INC: begin
            res   = off_ff + 8'd1;
            wrote = 1'b1;
         end
         OP_DEC: begin
            res   = off_ff - 8'd1;
            wrote = 1'b1;
         end
         OP_ADD: begin
            res   = a_ff + b_ff;
            wrote = 1'b1;
         end
         OP_SUB: begin
            res   = a_ff - b_ff;
            wrote = 1'b1;
         end
         OP_MUL: begin
            res   = 8'(a_ff * b_ff);
            wrote = 1'b1;
         end
         OP_DIV: begin
            wrote = 1'b1;
            if (b_ff == 8'd0) begin
               status = ST_DIV_ZERO;
            end else begin
               res = div_q_ff;
            end
         end
         OP_CMP: begin
            res   = {7'd0, (a_ff & b_ff) == b_ff};
            wrote = 1'b1;
         end
         OP_JMP, OP_RJMP: begin
            jump_take = 1'b1;
         end
         OP_JNZ_F, OP_JNZ_B: begin
            jump_take = (a_ff != 8'd0);
         end
         OP_JZ_F, OP_JZ_B: begin
            jump_take = (a_ff == 8'd0);
         end
         OP_JLT_F, OP_JLT_B, OP_JLU_F, OP_JLU_B, OP_JLA_F, OP_JLA_B: begin
            jump_take = (a_ff < b_ff);
         end
         OP_JGT_F, OP_JGT_B: begin
            jump_take = (a_ff > b_ff);
         end
         OP_AND: begin
            res   = a_ff & b_ff;
            wrote = 1'b1;
         end
         OP_OR: begin
            res   = a_ff | b_ff;
            wrote = 1'b1;
         end
         OP_XOR: begin
            res   = a_ff ^ b_ff;
            wrote = 1'b1;
         end
         OP_NOT: begin
            res   = ~off_ff;
            wrote = 1'b1;
         end
         OP_SHL: begin
            res   = (b_ff >= 8'd8) ? 8'd0 : 8'(a_ff << b_ff[2:0]);
            wrote = 1'b1;
         end
         OP_SHR: begin
            res   = (b_ff >= 8'd8) ? 8'd0 : (a_ff >> b_ff[2:0]);
            wrote = 1'b1;
         end
         default: begin
            status = ST_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      run_in    = run_ff;
      rf_we     = 1'b0;
      rf_waddr  = d_ff;
      rf_wdata  = res;
      stk_we    = 1'b0;
      stk_waddr = sp_ff;
      stk_wdata = off_ff;
      rep_val   = res;
      if (op_ff == OP_MOV && d_ff == s1_ff) begin
         rep_val = 8'd0;
      end
      if (cmd.clear_src) begin
         rf_we    = 1'b1;
         rf_waddr = s1_ff;
         rf_wdata = 8'd0;
      end else if (cmd.commit) begin
         if (cmd_ff == CMD_START) begin
            pc_in  = '0;
            sp_in  = SP_TOP;
            run_in = 1'b1;
         end else if (run_ff) begin
            pc_in = pc_step;
            if (jump_take) begin
               pc_in = op_ff[0] ? pc_step - PC_BITS'(off_ff) : pc_step + PC_BITS'(off_ff);
            end
            if (op_ff == OP_HALT) begin
               run_in = 1'b0;
            end
            rf_we = wrote;
            if (op_ff == OP_PUSH) begin
               stk_we = 1'b1;
               sp_in  = sp_dec;
            end
            if (op_ff == OP_POP) begin
               stk_we    = 1'b1;
               stk_waddr = sp_inc;
               stk_wdata = 8'd0;
               sp_in     = sp_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         sp_ff  <= SP_TOP;
         run_ff <= 1'b0;
      end else begin
         pc_ff  <= pc_in;
         sp_ff  <= sp_in;
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_tdata_ff[15:0] <= 16'(pc_in);
         rsp_tdata_ff[16]   <= run_in;
         if (cmd_ff == CMD_START) begin
            rsp_tdata_ff[18:17] <= ST_OK;
            rsp_tdata_ff[31:19] <= '0;
         end else if (!run_ff) begin
            rsp_tdata_ff[18:17] <= ST_HALTED;
            rsp_tdata_ff[31:19] <= '0;
         end else begin
            rsp_tdata_ff[18:17] <= status;
            rsp_tdata_ff[19]    <= wrote;
            rsp_tdata_ff[23:20] <= wrote ? d_ff : 4'd0;
            rsp_tdata_ff[31:24] <= wrote ? rep_val : 8'd0;
         end
      end
   end

   assign st.div_op   = exec_ok && (op_ff == OP_DIV);
   assign st.div_busy = div_busy_ff;
   assign st.mov_op   = exec_ok && (op_ff == OP_MOV);
   assign st.out_free = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/byte_register_vm_executor.sv -----
`timescale 1ns / 1ps
// Top level of the byte register machine executor.
// Joins bvx_ctrl and bvx_dpath. Uses bvx_pkg.
//
//  channel | direction | tdata                              | tuser
//  req     | in        | instruction[31:0]                  | command
//  rsp     | out       | next_pc, running, status, wrote,   | -
//          |           | written_index, written_value       |
//
// A request transfer passes through S_READ_OPS, S_EXECUTE and S_COMMIT before its result is
// registered for output, and the next request is taken once the controller is back in S_IDLE. Mov
// adds S_CLEAR_SRC to clear its source; div adds S_DIVIDE for eight bit-serial divider steps.
// A new item is accepted only once the previous one has committed; one
// finished result may wait in the output register meanwhile.
// Reset clears the register file and stack valid bits, pc and the run flag, and sets sp to the stack top.
// A stalled result holds the next commit until the output register frees.
module byte_register_vm_executor
   import bvx_pkg::*;
#(
   parameter int PC_BITS     = DEF_PC_BITS,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // instruction[31:0]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[15:0], running[16], status[18:17], wrote_register[19],
   // written_index[23:20], written_value[31:24]
   output logic [31:0] rsp_tdata
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   bvx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bvx_dpath #(
      .PC_BITS     (PC_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .st         (st),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/bvx_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the executor, bound to the top level.
// Tracks outstanding transfers. Uses bvx_pkg.
module bvx_checker
   import bvx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed or dropped while stalled.");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("Result transfer without an outstanding request.");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("More than two requests outstanding.");

   a_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:17] == ST_HALTED |-> !rsp_tdata[16] && !rsp_tdata[19])
      else $error("Ignored instruction reported as running or writing.");

endmodule

bind byte_register_vm_executor bvx_checker u_bvx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
